// File: rtl/core/ttsg_pkg.sv
// Shared types, codes and reset constants of the touchpad tap and swipe gesture detector.
// No dependencies; every other file of the block imports it.
package ttsg_pkg;

   localparam int DELTA_W  = 16;
   localparam int SUM_W    = 24;
   localparam int CNT_W    = 16;
   localparam int MOTION_W = 20;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 20;

   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic        [CNT_W-1:0]   cnt_type;
   typedef logic        [MOTION_W-1:0] motion_type;
   typedef logic        [CSR_AW-1:0]  csr_addr_type;
   typedef logic        [CSR_DW-1:0]  csr_data_type;

   // register indexes of the configuration port
   localparam csr_addr_type CSR_TAP_MAX_DURATION = 3'd0;
   localparam csr_addr_type CSR_TAP_MAX_MOTION   = 3'd1;
   localparam csr_addr_type CSR_MULTITAP_WINDOW  = 3'd2;
   localparam csr_addr_type CSR_SWIPE_MIN_MOTION = 3'd3;
   localparam csr_addr_type CSR_IDLE_TIMEOUT     = 3'd4;

   localparam cnt_type    TAP_MAX_DURATION_RST = 16'd200;
   localparam motion_type TAP_MAX_MOTION_RST   = 20'd50;
   localparam cnt_type    MULTITAP_WINDOW_RST  = 16'd250;
   localparam motion_type SWIPE_MIN_MOTION_RST = 20'd300;
   localparam cnt_type    IDLE_TIMEOUT_RST     = 16'd80;

   localparam cnt_type CNT_MAX = '1;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_TOUCHING = 2'd1,
      MODE_TAP_WAIT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      GEST_NONE  = 2'd0,
      GEST_CLICK = 2'd1,
      GEST_SWIPE = 2'd2
   } gesture_type;

   typedef enum logic [1:0] {
      BTN_LEFT   = 2'd0,
      BTN_RIGHT  = 2'd1,
      BTN_MIDDLE = 2'd2
   } button_type;

   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      AXIS_X     = 2'd0,
      AXIS_Y     = 2'd1,
      AXIS_OTHER = 2'd2
   } axis_type;

   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef struct packed {
      cnt_type    tap_max_duration;
      motion_type tap_max_motion;
      cnt_type    multitap_window;
      motion_type swipe_min_motion;
      cnt_type    idle_timeout;
   } cfg_type;

   typedef struct packed {
      logic      command;
      logic      is_relative;
      logic [1:0] axis;
      delta_type delta;
      logic      sync;
   } item_type;

   typedef struct packed {
      gesture_type gesture;
      button_type  button;
      dir_type     direction;
      sum_type     swipe_x;
      sum_type     swipe_y;
   } result_type;

endpackage

// File: rtl/core/ttsg_if.sv
// Valid/ready channel interfaces for the request (event or tick) and response (gesture) sides.
// Depends on ttsg_pkg.
interface ttsg_req_if;
   import ttsg_pkg::*;
   logic       valid;
   logic       ready;
   logic       command;
   logic       is_relative;
   logic [1:0] axis;
   delta_type  delta;
   logic       sync;

   modport source (output valid, command, is_relative, axis, delta, sync, input ready);
   modport sink   (input valid, command, is_relative, axis, delta, sync, output ready);
endinterface

interface ttsg_rsp_if;
   import ttsg_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] gesture;
   logic [1:0] button;
   logic [1:0] direction;
   sum_type    swipe_x;
   sum_type    swipe_y;

   modport source (output valid, gesture, button, direction, swipe_x, swipe_y, input ready);
   modport sink   (input valid, gesture, button, direction, swipe_x, swipe_y, output ready);
endinterface

// File: rtl/core/ttsg_csr.sv
// Configuration registers: thresholds and timeouts written through the plain write port.
// Depends on ttsg_pkg.
module ttsg_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  ttsg_pkg::csr_addr_type csr_index,
   input  ttsg_pkg::csr_data_type csr_wdata,
   output ttsg_pkg::cfg_type     cfg
);
   import ttsg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TAP_MAX_DURATION: cfg_in.tap_max_duration = csr_wdata[CNT_W-1:0];
            CSR_TAP_MAX_MOTION:   cfg_in.tap_max_motion   = csr_wdata[MOTION_W-1:0];
            CSR_MULTITAP_WINDOW:  cfg_in.multitap_window  = csr_wdata[CNT_W-1:0];
            CSR_SWIPE_MIN_MOTION: cfg_in.swipe_min_motion = csr_wdata[MOTION_W-1:0];
            CSR_IDLE_TIMEOUT:     cfg_in.idle_timeout     = csr_wdata[CNT_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_max_duration <= TAP_MAX_DURATION_RST;
         cfg_ff.tap_max_motion   <= TAP_MAX_MOTION_RST;
         cfg_ff.multitap_window  <= MULTITAP_WINDOW_RST;
         cfg_ff.swipe_min_motion <= SWIPE_MIN_MOTION_RST;
         cfg_ff.idle_timeout     <= IDLE_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/ttsg_core.sv
// Gesture state: touch sums, latched deltas, timers, tap count, mode; one item per cycle with accept.
// Depends on ttsg_pkg; feeds its result to ttsg_rsp_buf.
module ttsg_core (
   input  logic                  clock,
   input  logic                  reset,
   input  ttsg_pkg::cfg_type     cfg,
   input  logic                  accept,
   input  ttsg_pkg::item_type    item,
   output ttsg_pkg::result_type  result
);
   import ttsg_pkg::*;

   mode_type   mode_ff, mode_in;
   sum_type    sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   delta_type  lat_x_ff, lat_x_in, lat_y_ff, lat_y_in;
   cnt_type    touch_ff, touch_in, idle_ff, idle_in, win_ff, win_in;
   logic [1:0] taps_ff, taps_in;

   logic       is_tick, ev_rel, ev_sync;
   delta_type  lat_x_new, lat_y_new;
   cnt_type    touch_inc, idle_inc, win_inc;
   logic [SUM_W-1:0] mag_x, mag_y;
   logic [SUM_W:0]   total;
   logic       timeout_hit, is_tap, win_hit, is_swipe;
   sum_type    acc_x, acc_y;

   function automatic cnt_type cnt_sat_inc(input cnt_type c);
      cnt_sat_inc = (c == CNT_MAX) ? c : c + cnt_type'(1);
   endfunction

   function automatic sum_type sat_add(input sum_type a, input delta_type b);
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + (SUM_W+1)'(b);
      if (s[SUM_W] != s[SUM_W-1]) begin
         sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sat_add = s[SUM_W-1:0];
      end
   endfunction

   function automatic logic [SUM_W-1:0] magnitude(input sum_type v);
      magnitude = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
   endfunction

   assign is_tick = (item.command == CMD_TICK);
   assign ev_rel  = (item.command == CMD_EVENT) && item.is_relative;
   assign ev_sync = ev_rel && item.sync;

   assign lat_x_new = (ev_rel && item.axis == AXIS_X) ? item.delta : lat_x_ff;
   assign lat_y_new = (ev_rel && item.axis == AXIS_Y) ? item.delta : lat_y_ff;

   assign touch_inc = cnt_sat_inc(touch_ff);
   assign idle_inc  = cnt_sat_inc(idle_ff);
   assign win_inc   = cnt_sat_inc(win_ff);

   assign mag_x = magnitude(sum_x_ff);
   assign mag_y = magnitude(sum_y_ff);
   assign total = {1'b0, mag_x} + {1'b0, mag_y};

   // counters advance first, then compare
   assign timeout_hit = (idle_inc >= cfg.idle_timeout);
   assign is_tap      = (total < (SUM_W+1)'(cfg.tap_max_motion))
                        && (touch_inc < cfg.tap_max_duration);
   assign is_swipe    = (total >= (SUM_W+1)'(cfg.swipe_min_motion));
   assign win_hit     = (win_inc >= cfg.multitap_window);

   assign acc_x = sat_add(sum_x_ff, lat_x_new);
   assign acc_y = sat_add(sum_y_ff, lat_y_new);

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_TOUCHING: begin
            if (ev_sync) begin
               mode_in = MODE_TOUCHING;
            end else if (is_tick && timeout_hit) begin
               mode_in = is_tap ? MODE_TAP_WAIT : MODE_IDLE;
            end
         end
         MODE_TAP_WAIT: begin
            if (ev_sync) begin
               mode_in = MODE_TOUCHING;
            end else if (is_tick && win_hit) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            if (ev_sync) begin
               mode_in = MODE_TOUCHING;
            end
         end
      endcase
   end

   // data path and result
   always_comb begin
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      lat_x_in = lat_x_ff;
      lat_y_in = lat_y_ff;
      touch_in = touch_ff;
      idle_in  = idle_ff;
      win_in   = win_ff;
      taps_in  = taps_ff;
      result   = '{gesture: GEST_NONE, button: BTN_LEFT, direction: DIR_RIGHT,
                   swipe_x: '0, swipe_y: '0};
      if (ev_sync) begin
         if (mode_ff == MODE_TOUCHING) begin
            sum_x_in = acc_x;
            sum_y_in = acc_y;
         end else begin
            sum_x_in = SUM_W'(lat_x_new);
            sum_y_in = SUM_W'(lat_y_new);
            touch_in = '0;
         end
         win_in   = '0;
         idle_in  = '0;
         lat_x_in = '0;
         lat_y_in = '0;
      end else if (ev_rel) begin
         lat_x_in = lat_x_new;
         lat_y_in = lat_y_new;
      end else if (is_tick && mode_ff == MODE_TOUCHING) begin
         touch_in = touch_inc;
         idle_in  = idle_inc;
         if (timeout_hit) begin
            sum_x_in = '0;
            sum_y_in = '0;
            if (is_tap) begin
               if (taps_ff != 2'd3) begin
                  taps_in = taps_ff + 2'd1;
               end
               win_in = '0;
            end else begin
               taps_in = '0;
               if (is_swipe) begin
                  result.gesture = GEST_SWIPE;
                  if (mag_x > mag_y) begin
                     result.direction = (!sum_x_ff[SUM_W-1] && sum_x_ff != '0) ?
                                        DIR_RIGHT : DIR_LEFT;
                  end else begin
                     result.direction = (!sum_y_ff[SUM_W-1] && sum_y_ff != '0) ?
                                        DIR_DOWN : DIR_UP;
                  end
                  result.swipe_x = sum_x_ff;
                  result.swipe_y = sum_y_ff;
               end
            end
         end
      end else if (is_tick && mode_ff == MODE_TAP_WAIT) begin
         win_in = win_inc;
         if (win_hit) begin
            result.gesture = GEST_CLICK;
            case (taps_ff)
               2'd1:    result.button = BTN_LEFT;
               2'd2:    result.button = BTN_RIGHT;
               default: result.button = BTN_MIDDLE;
            endcase
            taps_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         lat_x_ff <= '0;
         lat_y_ff <= '0;
         touch_ff <= '0;
         idle_ff  <= '0;
         win_ff   <= '0;
         taps_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         lat_x_ff <= lat_x_in;
         lat_y_ff <= lat_y_in;
         touch_ff <= touch_in;
         idle_ff  <= idle_in;
         win_ff   <= win_in;
         taps_ff  <= taps_in;
      end
   end

   a_sync_touches: assert property (@(posedge clock) disable iff (reset)
      accept && ev_sync |=> mode_ff == MODE_TOUCHING && lat_x_ff == '0 && lat_y_ff == '0)
      else $error("sync transfer did not start or extend a touch");

   a_click_clears: assert property (@(posedge clock) disable iff (reset)
      accept && result.gesture == GEST_CLICK |=> mode_ff == MODE_IDLE && taps_ff == 2'd0)
      else $error("click left taps or mode behind");

   a_wait_has_taps: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_TAP_WAIT |-> taps_ff != 2'd0)
      else $error("waiting for a further tap with no tap counted");

endmodule

// File: rtl/core/ttsg_rsp_buf.sv
// Result register with a skid stage, so a new item is taken while a result still waits.
// Depends on ttsg_pkg.
module ttsg_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ttsg_pkg::result_type push_data,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ttsg_pkg::result_type out_data
);
   import ttsg_pkg::*;

   logic       main_v_ff, main_v_in, skid_v_ff, skid_v_in;
   result_type main_ff, main_in, skid_ff, skid_in;
   logic       pop;

   assign pop = main_v_ff && out_ready;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         // advance the skid entry once the head transfers
         if (pop) begin
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!main_v_ff || pop) begin
            main_in   = push_data;
            main_v_in = 1'b1;
         end else begin
            skid_in   = push_data;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         main_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign room      = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid entry held with empty result register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> !push)
      else $error("result pushed with both stages full");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      main_v_ff && !out_ready |=> main_v_ff && main_ff == $past(main_ff))
      else $error("stalled result lost or changed");

endmodule

// File: rtl/core/touchpad_tap_swipe_gesture_detector_top.sv
// Touchpad tap, multi-tap and swipe gesture detector. Every request transfer (a
// relative-motion event or a one-millisecond tick) yields exactly one response
// transfer, gesture none, click or swipe, in order. The block takes one request
// per clock cycle: the whole state update is one pass of adders and comparators
// from the request payload into the state registers and the result register,
// and a two-stage result buffer keeps req_ch.ready high while a single result
// waits; it drops only when two results are pending. Each result is registered
// in the result buffer before it reaches rsp_ch. Write the thresholds through
// the csr_ port only while no request is in flight and no response is pending.
// Depends on ttsg_pkg, ttsg_if, ttsg_csr, ttsg_core and ttsg_rsp_buf.
module touchpad_tap_swipe_gesture_detector_top (
   input  logic                   clock,
   input  logic                   reset,
   ttsg_req_if.sink               req_ch,
   ttsg_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  ttsg_pkg::csr_addr_type csr_index,
   input  ttsg_pkg::csr_data_type csr_wdata
);
   import ttsg_pkg::*;

   cfg_type    cfg;
   item_type   item;
   result_type core_result, rsp_result;
   logic       room, accept;

   assign item = '{command: req_ch.command, is_relative: req_ch.is_relative,
                   axis: req_ch.axis, delta: req_ch.delta, sync: req_ch.sync};

   assign req_ch.ready = room;
   assign accept       = req_ch.valid && room;

   ttsg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ttsg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .accept (accept),
      .item   (item),
      .result (core_result)
   );

   ttsg_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_result)
   );

   assign rsp_ch.gesture   = rsp_result.gesture;
   assign rsp_ch.button    = rsp_result.button;
   assign rsp_ch.direction = rsp_result.direction;
   assign rsp_ch.swipe_x   = rsp_result.swipe_x;
   assign rsp_ch.swipe_y   = rsp_result.swipe_y;

endmodule
